// ===== hw/rtl/qrs_pkg.sv =====
package qrs_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int DISC_WIDTH = 34;
	localparam int ROOT_WIDTH = 32;
	localparam int SQRT_FRAC  = 15;

	// internal arithmetic is modulo 2^64
	localparam int DATA_W    = 64;
	localparam int SQ_ROOT_W = 32;
	localparam int SQ_REM_W  = 34;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 64;
	localparam int DIV_SIDE_W = 2 + DISC_WIDTH + 2;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_DOUBLE = 2'd1,
		ST_TWO    = 2'd2,
		ST_DEGEN  = 2'd3
	} status_t;

	// clamp a signed quotient, given as magnitude and sign, to the root range
	function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [DATA_W-1:0] mag,
			input logic neg);
		logic [DATA_W-1:0] lim;
		logic [DATA_W-1:0] neg_mag;
		lim = DATA_W'(1) << (ROOT_WIDTH - 1);
		neg_mag = -mag;
		if (neg) begin
			if (mag > lim)
				return lim[ROOT_WIDTH-1:0];
			return neg_mag[ROOT_WIDTH-1:0];
		end
		if (mag > lim - DATA_W'(1))
			return ROOT_WIDTH'(lim - DATA_W'(1));
		return mag[ROOT_WIDTH-1:0];
	endfunction

endpackage

// ===== hw/rtl/qrs_if.sv =====
interface qrs_coef_if #(parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] coef_a;
	logic signed [COEF_WIDTH-1:0] coef_b;
	logic signed [COEF_WIDTH-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
	logic                                     valid;
	logic                                     ready;
	logic [1:0]                               status;
	logic signed [qrs_pkg::DISC_WIDTH-1:0]    discriminant;
	logic signed [qrs_pkg::ROOT_WIDTH-1:0]    root_plus;
	logic signed [qrs_pkg::ROOT_WIDTH-1:0]    root_minus;

	modport source (output valid, status, discriminant, root_plus, root_minus, input ready);
	modport sink (input valid, status, discriminant, root_plus, root_minus, output ready);
endinterface

// ===== hw/rtl/qrs_sqrt_cell.sv =====
// one result bit of the integer square root per cell
module qrs_sqrt_cell #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_i,
	input  logic [qrs_pkg::DATA_W-1:0]    v_i,
	input  logic [qrs_pkg::SQ_REM_W-1:0]  rem_i,
	input  logic [qrs_pkg::SQ_ROOT_W-1:0] root_i,
	input  logic [SIDE_W-1:0]             side_i,
	output logic                          valid_o,
	output logic [qrs_pkg::DATA_W-1:0]    v_o,
	output logic [qrs_pkg::SQ_REM_W-1:0]  rem_o,
	output logic [qrs_pkg::SQ_ROOT_W-1:0] root_o,
	output logic [SIDE_W-1:0]             side_o
);
	localparam int CW = qrs_pkg::SQ_REM_W + 2;

	logic [CW-1:0] cur;
	logic [CW-1:0] trial;
	logic [CW-1:0] diff;
	logic          ge;

	always_comb begin
		cur   = {rem_i, v_i[qrs_pkg::DATA_W-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		diff  = cur - trial;
		ge    = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_o    <= {v_i[qrs_pkg::DATA_W-3:0], 2'b00};
			rem_o  <= ge ? diff[qrs_pkg::SQ_REM_W-1:0] : cur[qrs_pkg::SQ_REM_W-1:0];
			root_o <= {root_i[qrs_pkg::SQ_ROOT_W-2:0], ge};
			side_o <= side_i;
		end
	end

endmodule

// ===== hw/rtl/qrs_div_cell.sv =====
// one quotient bit per cell for both roots; dividend shifts out as quotient shifts in
module qrs_div_cell #(
	parameter int DEN_W  = qrs_pkg::COEF_WIDTH_DEF,
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_i,
	input  logic [DEN_W-1:0]           den_i,
	input  logic [qrs_pkg::DATA_W-1:0] np_i,
	input  logic [DEN_W-1:0]           rp_i,
	input  logic [qrs_pkg::DATA_W-1:0] nm_i,
	input  logic [DEN_W-1:0]           rm_i,
	input  logic [SIDE_W-1:0]          side_i,
	output logic                       valid_o,
	output logic [DEN_W-1:0]           den_o,
	output logic [qrs_pkg::DATA_W-1:0] np_o,
	output logic [DEN_W-1:0]           rp_o,
	output logic [qrs_pkg::DATA_W-1:0] nm_o,
	output logic [DEN_W-1:0]           rm_o,
	output logic [SIDE_W-1:0]          side_o
);
	localparam int DW = qrs_pkg::DATA_W;

	logic [DEN_W:0] cur_p, cur_m, dif_p, dif_m;
	logic           ge_p, ge_m;

	always_comb begin
		cur_p = {rp_i, np_i[DW-1]};
		cur_m = {rm_i, nm_i[DW-1]};
		dif_p = cur_p - {1'b0, den_i};
		dif_m = cur_m - {1'b0, den_i};
		ge_p  = (cur_p >= {1'b0, den_i});
		ge_m  = (cur_m >= {1'b0, den_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o  <= den_i;
			np_o   <= {np_i[DW-2:0], ge_p};
			nm_o   <= {nm_i[DW-2:0], ge_m};
			rp_o   <= ge_p ? dif_p[DEN_W-1:0] : cur_p[DEN_W-1:0];
			rm_o   <= ge_m ? dif_m[DEN_W-1:0] : cur_m[DEN_W-1:0];
			side_o <= side_i;
		end
	end

endmodule

// ===== hw/rtl/quadratic_root_solver.sv =====
// channel | dir | payload                                          | transfer
// coef    | in  | coef_a, coef_b, coef_c (signed, FRAC_BITS frac)  | valid & ready
// root    | out | status, discriminant Q18.16, root_plus/minus     | valid & ready
//
// One coefficient set per cycle while the output does not wait on ready.
// Pipeline: two product/discriminant stages, 32 square root cells, one stage for
// the dividends, 64 divider cells and the output register.
// The whole pipeline advances together; it holds while the output waits on ready.
// arst_n clears all valid bits; data registers are not reset.
module quadratic_root_solver #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	qrs_coef_if.sink  coef,
	qrs_root_if.source root
);
	localparam int W      = COEF_WIDTH;
	localparam int DW     = qrs_pkg::DATA_W;
	localparam int DQW    = qrs_pkg::DISC_WIDTH;
	localparam int NSQ    = qrs_pkg::SQ_STEPS;
	localparam int NDV    = qrs_pkg::DIV_STEPS;
	localparam int SQ_SIDE_W = 2 + DQW + DW + W;
	localparam int DV_SIDE_W = qrs_pkg::DIV_SIDE_W;

	logic en;
	assign en = !root.valid || root.ready;
	assign coef.ready = en;

	// stage 1: products
	logic                  valid_s1;
	logic signed [W-1:0]   a_s1, b_s1;
	logic signed [2*W-1:0] bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef.coef_a;
			b_s1  <= coef.coef_b;
			bb_s1 <= coef.coef_b * coef.coef_b;
			ac_s1 <= coef.coef_a * coef.coef_c;
		end
	end

	// stage 2: discriminant and classification
	logic signed [DW-1:0] bb64, ac64, b64, du, dq_full;
	logic [DW-1:0]        base, v;
	qrs_pkg::status_t     st;

	always_comb begin
		bb64 = DW'(bb_s1);
		ac64 = DW'(ac_s1);
		b64  = DW'(b_s1);
		du   = bb64 - (ac64 <<< 2);
		v    = du << 30;
		base = -(b64 <<< qrs_pkg::SQRT_FRAC);
		if (a_s1 == '0)
			st = qrs_pkg::ST_DEGEN;
		else if (du[DW-1])
			st = qrs_pkg::ST_NONE;
		else if (du == '0)
			st = qrs_pkg::ST_DOUBLE;
		else
			st = qrs_pkg::ST_TWO;
	end

	generate
		if (2 * FRAC_BITS <= 16) begin : g_dq_up
			assign dq_full = du <<< (16 - 2 * FRAC_BITS);
		end else begin : g_dq_down
			assign dq_full = du >>> (2 * FRAC_BITS - 16);
		end
	endgenerate

	logic                          sq_valid [NSQ+1];
	logic [DW-1:0]                 sq_v     [NSQ+1];
	logic [qrs_pkg::SQ_REM_W-1:0]  sq_rem   [NSQ+1];
	logic [qrs_pkg::SQ_ROOT_W-1:0] sq_root  [NSQ+1];
	logic [SQ_SIDE_W-1:0]          sq_side  [NSQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_valid[0] <= 1'b0;
		end else if (en) begin
			sq_valid[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_v[0]    <= v;
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_side[0] <= {st, dq_full[DQW-1:0], base, a_s1};
		end
	end

	for (genvar i = 0; i < NSQ; i++) begin : g_sq
		qrs_sqrt_cell #(.SIDE_W(SQ_SIDE_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (sq_valid[i]),
			.v_i     (sq_v[i]),
			.rem_i   (sq_rem[i]),
			.root_i  (sq_root[i]),
			.side_i  (sq_side[i]),
			.valid_o (sq_valid[i+1]),
			.v_o     (sq_v[i+1]),
			.rem_o   (sq_rem[i+1]),
			.root_o  (sq_root[i+1]),
			.side_o  (sq_side[i+1])
		);
	end

	// dividend stage: signed numerators to magnitudes
	logic [W-1:0]   sq_a;
	logic [DW-1:0]  sq_base, num_p, num_m, mag_p, mag_m;
	logic [DQW-1:0] sq_dq;
	logic [1:0]     sq_st;
	logic [W-1:0]   den;
	logic           a_neg;

	always_comb begin
		sq_a    = sq_side[NSQ][W-1:0];
		sq_base = sq_side[NSQ][W+DW-1:W];
		sq_dq   = sq_side[NSQ][W+DW+DQW-1:W+DW];
		sq_st   = sq_side[NSQ][SQ_SIDE_W-1 -: 2];
		a_neg   = sq_a[W-1];
		den     = a_neg ? -sq_a : sq_a;
		num_p   = sq_base + DW'(sq_root[NSQ]);
		num_m   = sq_base - DW'(sq_root[NSQ]);
		mag_p   = num_p[DW-1] ? -num_p : num_p;
		mag_m   = num_m[DW-1] ? -num_m : num_m;
	end

	logic                 dv_valid [NDV+1];
	logic [W-1:0]         dv_den   [NDV+1];
	logic [DW-1:0]        dv_np    [NDV+1];
	logic [W-1:0]         dv_rp    [NDV+1];
	logic [DW-1:0]        dv_nm    [NDV+1];
	logic [W-1:0]         dv_rm    [NDV+1];
	logic [DV_SIDE_W-1:0] dv_side  [NDV+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid[0] <= 1'b0;
		end else if (en) begin
			dv_valid[0] <= sq_valid[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_den[0]  <= den;
			dv_np[0]   <= mag_p;
			dv_nm[0]   <= mag_m;
			dv_rp[0]   <= '0;
			dv_rm[0]   <= '0;
			dv_side[0] <= {sq_st, sq_dq, num_p[DW-1] ^ a_neg, num_m[DW-1] ^ a_neg};
		end
	end

	for (genvar j = 0; j < NDV; j++) begin : g_dv
		qrs_div_cell #(.DEN_W(W), .SIDE_W(DV_SIDE_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (dv_valid[j]),
			.den_i   (dv_den[j]),
			.np_i    (dv_np[j]),
			.rp_i    (dv_rp[j]),
			.nm_i    (dv_nm[j]),
			.rm_i    (dv_rm[j]),
			.side_i  (dv_side[j]),
			.valid_o (dv_valid[j+1]),
			.den_o   (dv_den[j+1]),
			.np_o    (dv_np[j+1]),
			.rp_o    (dv_rp[j+1]),
			.nm_o    (dv_nm[j+1]),
			.rm_o    (dv_rm[j+1]),
			.side_o  (dv_side[j+1])
		);
	end

	// output register: saturate and mask roots by status
	logic [1:0]                       fin_st;
	logic [qrs_pkg::ROOT_WIDTH-1:0]   fin_p, fin_m;
	logic                             has_roots;

	always_comb begin
		fin_st    = dv_side[NDV][DV_SIDE_W-1 -: 2];
		has_roots = (fin_st == qrs_pkg::ST_DOUBLE) || (fin_st == qrs_pkg::ST_TWO);
		fin_p     = has_roots ? qrs_pkg::sat_root(dv_np[NDV], dv_side[NDV][1]) : '0;
		fin_m     = has_roots ? qrs_pkg::sat_root(dv_nm[NDV], dv_side[NDV][0]) : '0;
	end

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_valid[NDV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root.status       <= fin_st;
			root.discriminant <= dv_side[NDV][DQW+1:2];
			root.root_plus    <= fin_p;
			root.root_minus   <= fin_m;
		end
	end

	assign root.valid = valid_q;

endmodule

// ===== hw/rtl/qrs_checker.sv =====
module qrs_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [1:0]                            status,
	input logic [qrs_pkg::ROOT_WIDTH-1:0]        root_plus,
	input logic [qrs_pkg::ROOT_WIDTH-1:0]        root_minus
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == qrs_pkg::ST_DEGEN) |-> (root_plus == '0) && (root_minus == '0))
		else $error("degenerate equation with nonzero roots");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == qrs_pkg::ST_NONE) |-> (root_plus == '0) && (root_minus == '0))
		else $error("no real root but nonzero roots");

	a_double: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == qrs_pkg::ST_DOUBLE) |-> (root_plus == root_minus))
		else $error("double root with differing roots");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (root.valid),
	.out_ready  (root.ready),
	.status     (root.status),
	.root_plus  (root.root_plus),
	.root_minus (root.root_minus)
);

// ===== bench/quadratic_root_solver_test.sv =====
module quadratic_root_solver_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		qrs_pkg::status_t                  status;
		logic [qrs_pkg::DISC_WIDTH-1:0]    disc;
		logic [qrs_pkg::ROOT_WIDTH-1:0]    rp;
		logic [qrs_pkg::ROOT_WIDTH-1:0]    rm;
	} roots_t;

	class root_board;
		roots_t pending[$];
		int     errors;

		static function logic [63:0] isqrt(logic [63:0] v);
			logic [63:0] r, bitv;
			r = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= r + bitv) begin
					v = v - (r + bitv);
					r = (r >> 1) + bitv;
				end else
					r >>= 1;
				bitv >>= 2;
			end
			return r;
		endfunction

		static function logic [qrs_pkg::ROOT_WIDTH-1:0] clamp_div(longint num, longint den);
			longint q;
			q = num / den;
			if (q > 64'sd2147483647)
				q = 64'sd2147483647;
			if (q < -64'sd2147483648)
				q = -64'sd2147483648;
			return q[qrs_pkg::ROOT_WIDTH-1:0];
		endfunction

		function void note_coefs(logic signed [15:0] a, logic signed [15:0] b,
				logic signed [15:0] c);
			roots_t e;
			longint sa, sb, sc, d, base;
			logic [63:0] s;
			sa = a;
			sb = b;
			sc = c;
			d = sb * sb - 4 * sa * sc;
			e.disc = qrs_pkg::DISC_WIDTH'(d);   // Q18.16 from Q8.8 squared: no shift
			e.rp = '0;
			e.rm = '0;
			if (sa == 0)
				e.status = qrs_pkg::ST_DEGEN;
			else if (d < 0)
				e.status = qrs_pkg::ST_NONE;
			else begin
				s = isqrt(64'(d) << 30);
				base = -(sb <<< qrs_pkg::SQRT_FRAC);
				if (d == 0) begin
					e.status = qrs_pkg::ST_DOUBLE;
					e.rp = clamp_div(base, sa);
					e.rm = e.rp;
				end else begin
					e.status = qrs_pkg::ST_TWO;
					e.rp = clamp_div(base + longint'(s), sa);
					e.rm = clamp_div(base - longint'(s), sa);
				end
			end
			pending.push_back(e);
		endfunction

		function void check_roots(logic [1:0] st, logic [qrs_pkg::DISC_WIDTH-1:0] disc,
				logic [qrs_pkg::ROOT_WIDTH-1:0] rp, logic [qrs_pkg::ROOT_WIDTH-1:0] rm);
			roots_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (disc !== e.disc) begin
				$error("discriminant: expected %h, got %h", e.disc, disc);
				errors++;
			end
			if (rp !== e.rp) begin
				$error("root_plus: expected %h, got %h", e.rp, rp);
				errors++;
			end
			if (rm !== e.rm) begin
				$error("root_minus: expected %h, got %h", e.rm, rm);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	int   send_idle = 0;
	int   recv_stall = 0;
	int   quiet = 0;
	root_board board = new();

	qrs_coef_if coef_ch ();
	qrs_root_if root_ch ();

	quadratic_root_solver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.coef(coef_ch.sink),
		.root(root_ch.source)
	);

	always #10 clk = ~clk;

	initial begin
		coef_ch.valid = 0;
		coef_ch.coef_a = 0;
		coef_ch.coef_b = 0;
		coef_ch.coef_c = 0;
		root_ch.ready = 0;
	end

	always @(posedge clk)
		if (arst_n)
			root_ch.ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if (arst_n && root_ch.valid && root_ch.ready)
			board.check_roots(root_ch.status, root_ch.discriminant,
				root_ch.root_plus, root_ch.root_minus);
		if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 5000) begin
			$display("quadratic_root_solver_test: FAIL");
			$finish;
		end
	end

	// valid stays up from one transfer to the next unless the sender idles
	task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
			logic signed [15:0] c);
		while ($urandom_range(99) < send_idle) begin
			coef_ch.valid <= 0;
			@(posedge clk);
		end
		coef_ch.valid <= 1;
		coef_ch.coef_a <= a;
		coef_ch.coef_b <= b;
		coef_ch.coef_c <= c;
		do
			@(posedge clk);
		while (!coef_ch.ready);
		board.note_coefs(a, b, c);
	endtask

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(5))
			0: return 16'h8000 + 16'($urandom_range(2));
			1: return 16'h7fff - 16'($urandom_range(2));
			2: return 16'($signed($urandom_range(512)) - 256);
			3: return 16'($urandom_range(4) << 8);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [15:0] a, b, c;
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// degenerate, no root, double root, two roots, extremes
		send_coefs(0, 16'sh0100, 16'sh0200);
		send_coefs(0, 0, 0);
		send_coefs(16'sh0100, 0, 16'sh0100);
		send_coefs(16'sh0100, 16'sh0200, 16'sh0100);
		send_coefs(16'sh0100, 16'shfc00, 16'sh0400);
		send_coefs(16'sh0100, 0, 16'shff00);
		send_coefs(16'sh0100, 16'sh0300, 16'sh0200);
		send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
		send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
		send_coefs(16'sh0001, 16'sh8000, 0);
		send_coefs(16'sh0001, 16'sh7fff, 0);
		send_coefs(16'shffff, 16'sh8000, 16'sh0001);
		send_coefs(16'sh0001, 16'sh0002, 16'sh0001);
		send_coefs(16'shffff, 16'sh0002, 16'shffff);
		send_coefs(16'sh8000, 0, 16'sh7fff);
		send_coefs(16'sh7fff, 0, 16'sh8000);
		send_coefs(16'sh0001, 0, 0);
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: send_idle = 74;
				2: begin send_idle = 0; recv_stall = 74; end
				3: send_idle = 33;
				4: begin send_idle = 0; recv_stall = 0; end
				default: ;
			endcase
			if (ph == 3)
				recv_stall = 33;
			for (int i = 0; i < 380; i++) begin
				a = rand_coef();
				b = rand_coef();
				c = rand_coef();
				r = $urandom_range(9);
				// steer some sets onto a zero discriminant: b = 2k, a*c = k*k
				if (r == 0) begin
					a = 16'($signed($urandom_range(64)) - 32);
					c = a;
					b = 16'(2 * a);
					if ($urandom_range(1))
						b = -b;
				end else if (r == 1)
					a = 0;
				send_coefs(a, b, c);
			end
		end
		coef_ch.valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (board.errors == 0)
			$display("quadratic_root_solver_test: PASS");
		else
			$display("quadratic_root_solver_test: FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_if.sv
hw/rtl/qrs_sqrt_cell.sv
hw/rtl/qrs_div_cell.sv
hw/rtl/quadratic_root_solver.sv
hw/rtl/qrs_checker.sv
bench/quadratic_root_solver_test.sv
